// File: sv/itc_pkg.sv
// Shared types, codes and helpers for the interval timer counters block.
package itc_pkg;

    localparam int ITC_MAX_COUNTERS = 3;
    localparam int ITC_NUM_COUNTERS = 3;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } itc_op_t;

    localparam logic [1:0] ADDR_CONTROL = 2'd3;

    typedef enum logic [1:0] {
        ACC_LATCH = 2'd0,
        ACC_LOW   = 2'd1,
        ACC_HIGH  = 2'd2,
        ACC_BOTH  = 2'd3
    } itc_access_t;

    typedef enum logic [2:0] {
        MODE_TC_INT      = 3'd0,
        MODE_GATED_PULSE = 3'd1,
        MODE_RATE        = 3'd2,
        MODE_SQUARE      = 3'd3,
        MODE_SW_STROBE   = 3'd4,
        MODE_HW_STROBE   = 3'd5
    } itc_mode_t;

    typedef struct packed {
        itc_op_t    opcode;
        logic [1:0] address;
        logic [7:0] write_data;
    } itc_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] out_levels;
    } itc_out_t;

    // Per-counter strobes for one accepted word
    typedef struct packed {
        logic       tick;
        logic       ctrl_wr;
        logic       data_wr;
        logic       data_rd;
        logic [7:0] data;
    } itc_ctl_t;

    // Modes 6 and 7 alias onto 2 and 3
    function automatic itc_mode_t fold_mode(logic [2:0] raw);
        logic [2:0] m;
        m = (raw[2] && raw[1]) ? {1'b0, raw[1:0]} : raw;
        return itc_mode_t'(m);
    endfunction

    function automatic logic [15:0] low_phase_load(logic [15:0] n);
        return (n == 16'd1) ? 16'd2 : {n[15:1], 1'b0};
    endfunction

endpackage

// File: sv/itc_ifs.sv
// Valid/ready channel interfaces for the command and response words.
interface itc_cmd_if
    import itc_pkg::*;
();
    logic    valid;
    logic    ready;
    itc_in_t payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

interface itc_rsp_if
    import itc_pkg::*;
();
    logic     valid;
    logic     ready;
    itc_out_t payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

// File: sv/itc_counter.sv
// One 16-bit down counter with its mode, byte sequencing and count latch.
module itc_counter
    import itc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  itc_ctl_t   ctl,
    output logic [7:0] rd_byte,
    output logic       level,
    output logic       level_next
);

    logic [15:0] count_reg, count_next;
    logic [15:0] reload_reg, reload_next;
    itc_mode_t   mode_reg, mode_next;
    itc_access_t access_reg, access_next;
    logic        armed_reg, armed_next;
    logic        pending_reg, pending_next;
    logic        out_reg, out_next;
    logic        wr_high_reg, wr_high_next;
    logic        rd_high_reg, rd_high_next;
    logic [15:0] latched_reg, latched_next;
    logic        latch_valid_reg, latch_valid_next;
    logic [7:0]  low_hold_reg, low_hold_next;

    logic        written;
    logic [15:0] src;
    logic [15:0] dec;
    itc_access_t cw_access;
    itc_mode_t   cw_mode;

    always_comb
    begin
        count_next       = count_reg;
        reload_next      = reload_reg;
        mode_next        = mode_reg;
        access_next      = access_reg;
        armed_next       = armed_reg;
        pending_next     = pending_reg;
        out_next         = out_reg;
        wr_high_next     = wr_high_reg;
        rd_high_next     = rd_high_reg;
        latched_next     = latched_reg;
        latch_valid_next = latch_valid_reg;
        low_hold_next    = low_hold_reg;
        rd_byte          = '0;
        written          = 1'b0;
        src              = latch_valid_reg ? latched_reg : count_reg;
        dec              = count_reg - 16'd1;
        cw_access        = itc_access_t'(ctl.data[5:4]);
        cw_mode          = fold_mode(ctl.data[3:1]);

        if (ctl.ctrl_wr)
        begin
            if (cw_access == ACC_LATCH)
            begin
                if (!latch_valid_reg)
                begin
                    latched_next     = count_reg;
                    latch_valid_next = 1'b1;
                end
            end
            else
            begin
                mode_next        = cw_mode;
                access_next      = cw_access;
                armed_next       = 1'b0;
                pending_next     = 1'b0;
                wr_high_next     = 1'b0;
                rd_high_next     = 1'b0;
                latch_valid_next = 1'b0;
                out_next         = (cw_mode != MODE_TC_INT);
            end
        end
        else if (ctl.data_wr)
        begin
            unique case (access_reg)
                ACC_LOW:
                begin
                    reload_next = {8'h00, ctl.data};
                    written     = 1'b1;
                end
                ACC_HIGH:
                begin
                    reload_next = {ctl.data, 8'h00};
                    written     = 1'b1;
                end
                default:
                begin
                    if (!wr_high_reg)
                    begin
                        low_hold_next = ctl.data;
                        wr_high_next  = 1'b1;
                        // first byte of a mode 0 rewrite stops counting
                        if (mode_reg == MODE_TC_INT)
                            armed_next = 1'b0;
                    end
                    else
                    begin
                        reload_next  = {ctl.data, low_hold_reg};
                        wr_high_next = 1'b0;
                        written      = 1'b1;
                    end
                end
            endcase
            if (written)
            begin
                unique case (mode_reg)
                    MODE_TC_INT:
                    begin
                        out_next     = 1'b0;
                        pending_next = 1'b1;
                    end
                    MODE_RATE, MODE_SQUARE:
                    begin
                        if (!armed_reg)
                            pending_next = 1'b1;
                    end
                    MODE_SW_STROBE:
                    begin
                        out_next     = 1'b1;
                        pending_next = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (ctl.data_rd)
        begin
            unique case (access_reg)
                ACC_LOW:
                begin
                    rd_byte          = src[7:0];
                    latch_valid_next = 1'b0;
                end
                ACC_HIGH:
                begin
                    rd_byte          = src[15:8];
                    latch_valid_next = 1'b0;
                end
                default:
                begin
                    if (!rd_high_reg)
                    begin
                        rd_byte      = src[7:0];
                        rd_high_next = 1'b1;
                    end
                    else
                    begin
                        rd_byte          = src[15:8];
                        rd_high_next     = 1'b0;
                        latch_valid_next = 1'b0;
                    end
                end
            endcase
        end
        else if (ctl.tick)
        begin
            // a pending load takes the tick instead of a decrement
            if (pending_reg)
            begin
                pending_next = 1'b0;
                armed_next   = 1'b1;
                count_next   = reload_reg;
                if (mode_reg == MODE_SQUARE)
                    out_next = 1'b1;
            end
            else if (armed_reg)
            begin
                unique case (mode_reg)
                    MODE_TC_INT:
                    begin
                        count_next = dec;
                        if (dec == 16'd0)
                            out_next = 1'b1;
                    end
                    MODE_RATE:
                    begin
                        if (count_reg == 16'd1)
                        begin
                            count_next = reload_reg;
                            out_next   = 1'b1;
                        end
                        else
                        begin
                            count_next = dec;
                            out_next   = (dec != 16'd1);
                        end
                    end
                    MODE_SQUARE:
                    begin
                        if (count_reg == 16'd1 || count_reg == 16'd2)
                        begin
                            out_next   = ~out_reg;
                            count_next = out_reg ? low_phase_load(reload_reg) : reload_reg;
                        end
                        else
                            count_next = count_reg - 16'd2;
                    end
                    MODE_SW_STROBE:
                    begin
                        if (!out_reg)
                        begin
                            out_next   = 1'b1;
                            armed_next = 1'b0;
                        end
                        else
                        begin
                            count_next = dec;
                            if (dec == 16'd0)
                                out_next = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            reload_reg      <= '0;
            mode_reg        <= MODE_TC_INT;
            access_reg      <= ACC_BOTH;
            armed_reg       <= 1'b0;
            pending_reg     <= 1'b0;
            out_reg         <= 1'b1;
            wr_high_reg     <= 1'b0;
            rd_high_reg     <= 1'b0;
            latched_reg     <= '0;
            latch_valid_reg <= 1'b0;
            low_hold_reg    <= '0;
        end
        else
        begin
            count_reg       <= count_next;
            reload_reg      <= reload_next;
            mode_reg        <= mode_next;
            access_reg      <= access_next;
            armed_reg       <= armed_next;
            pending_reg     <= pending_next;
            out_reg         <= out_next;
            wr_high_reg     <= wr_high_next;
            rd_high_reg     <= rd_high_next;
            latched_reg     <= latched_next;
            latch_valid_reg <= latch_valid_next;
            low_hold_reg    <= low_hold_next;
        end
    end

    assign level      = out_reg;
    assign level_next = out_next;

endmodule

// File: sv/interval_timer_counters_top.sv
// Interval timer top: command decode, counter channels and response register.
// The response word for a command is registered and appears in the cycle after acceptance.
// Throughput: one command per cycle; the command side stalls only while a
// response waits and the sink holds ready low.
// Reset: asynchronous active-low; every counter returns to mode 0, both-byte
// access, stopped, output high; the response register empties.
module interval_timer_counters_top
    import itc_pkg::*;
#(
    parameter int NUM_COUNTERS = ITC_NUM_COUNTERS
)
(
    input  logic          clk,
    input  logic          rst_n,
    itc_cmd_if.sink       cmd,
    itc_rsp_if.source     rsp
);

    logic     accept;
    itc_out_t rsp_reg;
    logic     rsp_valid_reg;
    logic [ITC_MAX_COUNTERS-1:0] levels_cur;
    logic [ITC_MAX_COUNTERS-1:0] levels_next;
    logic [7:0] rd_bytes [NUM_COUNTERS];
    logic [7:0] rd_merged;

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    for (genvar i = 0; i < ITC_MAX_COUNTERS; i++)
    begin : g_chan
        if (i < NUM_COUNTERS)
        begin : g_on
            itc_ctl_t ctl;

            always_comb
            begin
                ctl.tick    = accept && (cmd.payload.opcode == OP_TICK);
                ctl.ctrl_wr = accept && (cmd.payload.opcode == OP_WRITE)
                              && (cmd.payload.address == ADDR_CONTROL)
                              && (cmd.payload.write_data[7:6] == 2'(i));
                ctl.data_wr = accept && (cmd.payload.opcode == OP_WRITE)
                              && (cmd.payload.address == 2'(i));
                ctl.data_rd = accept && (cmd.payload.opcode == OP_READ)
                              && (cmd.payload.address == 2'(i));
                ctl.data    = cmd.payload.write_data;
            end

            itc_counter u_counter (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .rd_byte    (rd_bytes[i]),
                .level      (levels_cur[i]),
                .level_next (levels_next[i])
            );
        end
        else
        begin : g_off
            assign levels_cur[i]  = 1'b0;
            assign levels_next[i] = 1'b0;
        end
    end

    // at most one channel drives a nonzero byte
    always_comb
    begin
        rd_merged = '0;
        for (int k = 0; k < NUM_COUNTERS; k++)
            rd_merged = rd_merged | rd_bytes[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (accept)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg.read_data  <= rd_merged;
            rsp_reg.out_levels <= levels_next;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

`ifndef SYNTHESIS
    a_rsp_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.valid)
        else $error("no response after accepted command");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.payload.opcode != OP_READ) |=> (rsp.payload.read_data == 8'h00))
        else $error("nonzero read byte for a non-read command");

    a_levels_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(levels_cur))
        else $error("output levels moved without a command");

    a_levels_match: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (rsp.payload.out_levels == levels_cur))
        else $error("response levels differ from counter outputs");
`endif

endmodule
